@@ hw/rtl/bmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants for the Boolean matrix product block.
// ----------------------------------------------------------------------------
package bmp_pkg;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int ROW_W            = 32;
    localparam int IDX_W_IN         = 5;
    localparam int SIZE_W           = 6;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;
    localparam logic REG_MATRIX_SIZE = 1'b0;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [IDX_W_IN-1:0] row;
        logic [ROW_W-1:0]    bits;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_COMPUTE
    } t_back_state;

    typedef struct packed {
        logic busy;
        logic pop;
    } t_back_status;

endpackage

@@ hw/rtl/bmp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_front
// Accepts input transfers, drops unused operations and out-of-range loads,
// and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module bmp_front
    import bmp_pkg::*;
#(
    parameter int ROW_LIMIT = DEF_MAX_VERTICES
) (
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                 i_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic w_keep;
    logic w_in_range;

    assign o_cmd.op   = t_op'(i_s_axis_tdata[1:0]);
    assign o_cmd.row  = i_s_axis_tdata[6:2];
    assign o_cmd.bits = i_s_axis_tdata[38:7];

    assign w_in_range = ({1'b0, o_cmd.row} < (IDX_W_IN + 1)'(ROW_LIMIT));

    always_comb begin
        w_keep = 1'b0;
        if (o_cmd.op == OP_COMPUTE) begin
            w_keep = 1'b1;
        end else if (o_cmd.op == OP_LOAD_A || o_cmd.op == OP_LOAD_B) begin
            w_keep = w_in_range;
        end
    end

    assign o_s_axis_tready = !i_full;
    assign o_push          = i_s_axis_tvalid && !i_full && w_keep;

endmodule

@@ hw/rtl/bmp_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module bmp_cmd_fifo
    import bmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_cmd,
    input  logic       i_pop,
    output t_cmd       o_head,
    output logic       o_empty,
    output logic       o_full,
    output logic [1:0] o_count
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_count = r_count;

endmodule

@@ hw/rtl/bmp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_back
// Holds both matrices, applies row loads and emits one product row per cycle,
// unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module bmp_back
    import bmp_pkg::*;
#(
    parameter int ROW_LIMIT = DEF_MAX_VERTICES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_head,
    input  logic                 i_empty,
    input  logic [SIZE_W-1:0]    i_matrix_size,
    output t_back_status         o_status,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                 o_m_axis_tlast
);

    localparam int IDX_W = $clog2(ROW_LIMIT);

    logic [ROW_LIMIT-1:0] r_left  [ROW_LIMIT];
    logic [ROW_LIMIT-1:0] r_right [ROW_LIMIT];
    logic [ROW_LIMIT-1:0] r_left_vld;
    logic [ROW_LIMIT-1:0] r_right_vld;

    t_back_state r_state;
    t_back_state n_state;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] n_row;
    logic [IDX_W-1:0] r_last_idx;
    logic [IDX_W-1:0] n_last_idx;

    logic                 r_m_valid;
    logic                 r_m_last;
    logic [IDX_W-1:0]     r_m_row;
    logic [ROW_LIMIT-1:0] r_m_bits;

    logic                 w_pop;
    logic                 w_adv;
    logic                 w_emit;
    logic                 w_wr_a;
    logic                 w_wr_b;
    logic [IDX_W-1:0]     w_wr_idx;
    logic [ROW_LIMIT-1:0] w_a_row;
    logic [ROW_LIMIT-1:0] w_prod;
    logic [ROW_LIMIT-1:0] w_col_terms;

    assign w_adv    = !r_m_valid || i_m_axis_tready;
    assign w_wr_idx = i_head.row[IDX_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_last_idx = r_last_idx;
        w_pop      = 1'b0;
        w_emit     = 1'b0;
        w_wr_a     = 1'b0;
        w_wr_b     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    w_pop = 1'b1;
                    if (i_head.op == OP_LOAD_A) begin
                        w_wr_a = 1'b1;
                    end else if (i_head.op == OP_LOAD_B) begin
                        w_wr_b = 1'b1;
                    end else begin
                        n_state = ST_COMPUTE;
                        n_row   = '0;
                        if (i_matrix_size == '0) begin
                            n_last_idx = '0;
                        end else if (i_matrix_size >= SIZE_W'(ROW_LIMIT)) begin
                            n_last_idx = IDX_W'(ROW_LIMIT - 1);
                        end else begin
                            n_last_idx = IDX_W'(i_matrix_size - SIZE_W'(1));
                        end
                    end
                end
            end
            ST_COMPUTE: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    if (r_row == r_last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row = r_row + IDX_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_last_idx <= n_last_idx;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_left[w_wr_idx] <= i_head.bits[ROW_LIMIT-1:0];
        end
        if (w_wr_b) begin
            r_right[w_wr_idx] <= i_head.bits[ROW_LIMIT-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_vld  <= '0;
            r_right_vld <= '0;
        end else begin
            if (w_wr_a) begin
                r_left_vld[w_wr_idx] <= 1'b1;
            end
            if (w_wr_b) begin
                r_right_vld[w_wr_idx] <= 1'b1;
            end
        end
    end

    // row i of the product: OR over k < n of (A[i][k] & B[k]), columns < n only
    assign w_a_row = r_left_vld[r_row] ? r_left[r_row] : '0;

    always_comb begin
        w_prod      = '0;
        w_col_terms = '0;
        for (int j = 0; j < ROW_LIMIT; j++) begin
            for (int k = 0; k < ROW_LIMIT; k++) begin
                w_col_terms[k] = w_a_row[k] && r_right_vld[k] && r_right[k][j]
                                 && (IDX_W'(k) <= r_last_idx);
            end
            w_prod[j] = (|w_col_terms) && (IDX_W'(j) <= r_last_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_m_row  <= r_row;
            r_m_bits <= w_prod;
            r_m_last <= (r_row == r_last_idx);
        end
    end

    assign o_status.busy = (r_state == ST_COMPUTE);
    assign o_status.pop  = w_pop;

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tdata  = {3'b000,
                              ROW_W'(r_m_bits),
                              IDX_W_IN'(r_m_row)};

endmodule

@@ hw/rtl/boolean_matrix_product_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boolean_matrix_product_top
// Boolean matrix product over 0/1 matrices loaded row by row.
// ----------------------------------------------------------------------------
// Throughput: loads one per cycle while the back end is idle; a compute holds it
// and yields one row per cycle through the AND-OR array unless output stalls.
// Reset: synchronous; matrix_size returns to 32 and per-row valid flags make
// both stores read as zero at once, with no clearing pass.
// ----------------------------------------------------------------------------
module boolean_matrix_product_top
    import bmp_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [PADDR_W-1:0]   i_paddr,
    input  logic [PDATA_W-1:0]   i_pwdata,
    output logic [PDATA_W-1:0]   o_prdata,
    output logic                 o_pready,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // operation[1:0], row_index[6:2], row_bits[38:7], zero pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // result_row_index[4:0], result_row_bits[36:5], zero pad
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                 o_m_axis_tlast
);

    localparam int ROW_LIMIT = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;

    logic [SIZE_W-1:0] r_matrix_size;
    logic              w_push;
    logic              w_full;
    logic              w_empty;
    logic [1:0]        w_count;
    t_cmd              w_cmd;
    t_cmd              w_head;
    t_back_status      w_status;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= SIZE_RESET;
        end else if (i_psel && i_penable && i_pwrite && i_paddr[2] == REG_MATRIX_SIZE) begin
            r_matrix_size <= i_pwdata[SIZE_W-1:0];
        end
    end

    assign o_prdata = (i_paddr[2] == REG_MATRIX_SIZE) ? PDATA_W'(r_matrix_size) : '0;

    bmp_front #(
        .ROW_LIMIT(ROW_LIMIT)
    ) u_front (
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_cmd          (w_cmd)
    );

    bmp_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_cmd),
        .i_pop  (w_status.pop),
        .o_head (w_head),
        .o_empty(w_empty),
        .o_full (w_full),
        .o_count(w_count)
    );

    bmp_back #(
        .ROW_LIMIT(ROW_LIMIT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_empty        (w_empty),
        .i_matrix_size  (r_matrix_size),
        .o_status       (w_status),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.busy |-> !w_status.pop)
        else $error("command dequeued during product run");

    a_run_open_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> w_status.busy)
        else $error("product run left unfinished");

    a_queue_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count != 2'd3)
        else $error("command queue overflow");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.pop |-> !w_empty)
        else $error("dequeue from empty command queue");

endmodule
